@@ hdl/fpmvt_pkg.sv @@
package fpmvt_pkg;

    localparam int unsigned Dim   = 4;
    localparam int unsigned WordW = 32;
    localparam int unsigned ProdW = 2 * WordW;
    localparam int unsigned RowW  = $clog2(Dim);

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_XFORM = 1'b1
    } t_mode;

    typedef logic signed [WordW-1:0] t_word;
    typedef logic signed [ProdW-1:0] t_prod;

    // one row or one vector
    typedef t_word [Dim-1:0] t_vec;

    // products, [row][column]
    typedef t_prod [Dim-1:0][Dim-1:0] t_prod_mat;

    // matrix row write
    typedef struct packed {
        logic            en;
        logic [RowW-1:0] row;
    } t_row_wr;

endpackage

@@ hdl/fpmvt_ifs.sv @@
interface fpmvt_in_if;
    import fpmvt_pkg::*;

    logic            valid;
    logic            ready;
    t_mode           mode;
    logic [RowW-1:0] row_index;
    t_word           elem0;
    t_word           elem1;
    t_word           elem2;
    t_word           elem3;

    modport source (
        output valid, mode, row_index, elem0, elem1, elem2, elem3,
        input  ready
    );
    modport sink (
        input  valid, mode, row_index, elem0, elem1, elem2, elem3,
        output ready
    );
endinterface

interface fpmvt_out_if;
    import fpmvt_pkg::*;

    logic  valid;
    logic  ready;
    t_word res0;
    t_word res1;
    t_word res2;
    t_word res3;

    modport source (
        output valid, res0, res1, res2, res3,
        input  ready
    );
    modport sink (
        input  valid, res0, res1, res2, res3,
        output ready
    );
endinterface

@@ hdl/fixed_point_matrix_vector_transform.sv @@
// 4x4 fixed-point matrix times vector.
//
// i_in (sink): one item per handshake. mode = MODE_LOAD writes elem0..3 into
//   matrix row row_index and yields nothing on o_out. mode = MODE_XFORM takes
//   elem0..3 as a vector; the item yields one o_out item whose res0..3 are
//   the row dot products, bits FRAC_BITS .. FRAC_BITS+31 of each 64-bit sum.
// o_out (source): valid/ready; payload holds while valid and not ready.
//
// Throughput: one item per cycle while i_in.ready is high, loads and
//   transforms mixed freely. A load takes effect for the very next item.
// Pipeline: products, pair sums, final sum and bit select, one register
//   stage each; the last stage is the output register.
// Stall: each stage has its own valid bit and moves when the stage after it
//   is free, so bubbles collapse; i_in.ready drops only once all three
//   stages hold items behind a stalled receiver.
// Reset: synchronous, active low; clears the matrix to zero and empties the
//   pipeline.
module fixed_point_matrix_vector_transform #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fpmvt_in_if.sink         i_in,
    fpmvt_out_if.source      o_out
);
    import fpmvt_pkg::*;

    t_vec      in_vec;
    t_row_wr   row_wr;
    logic      xform_valid;
    logic      mul_valid;
    logic      sum_ready;
    t_prod_mat prod;
    t_vec      res;

    assign in_vec[0] = i_in.elem0;
    assign in_vec[1] = i_in.elem1;
    assign in_vec[2] = i_in.elem2;
    assign in_vec[3] = i_in.elem3;

    // loads only update the matrix; transforms enter the pipeline
    assign row_wr.en   = i_in.valid && i_in.ready && (i_in.mode == MODE_LOAD);
    assign row_wr.row  = i_in.row_index;
    assign xform_valid = i_in.valid && (i_in.mode == MODE_XFORM);

    // stage 1: matrix store and the 16 products
    fpmvt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (row_wr),
        .i_vec   (in_vec),
        .i_valid (xform_valid),
        .o_ready (i_in.ready),
        .o_valid (mul_valid),
        .i_ready (sum_ready),
        .o_prod  (prod)
    );

    // stages 2 and 3: adder tree, fraction shift, output register
    fpmvt_sum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (sum_ready),
        .i_prod  (prod),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.res0 = res[0];
    assign o_out.res1 = res[1];
    assign o_out.res2 = res[2];
    assign o_out.res3 = res[3];

endmodule

@@ hdl/fpmvt_mul.sv @@
module fpmvt_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpmvt_pkg::t_row_wr  i_wr,
    input  fpmvt_pkg::t_vec     i_vec,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output fpmvt_pkg::t_prod_mat o_prod
);
    import fpmvt_pkg::*;

    t_vec      r_mat [Dim];
    logic      r_valid;
    t_prod_mat r_prod;
    t_prod_mat n_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    // 16 full 32x32 signed products against the current matrix
    always_comb begin
        for (int r = 0; r < Dim; r++) begin
            for (int c = 0; c < Dim; c++) begin
                n_prod[r][c] = t_prod'(r_mat[r][c]) * t_prod'(i_vec[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int r = 0; r < Dim; r++) begin
                r_mat[r] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (i_wr.en) begin
                r_mat[i_wr.row] <= i_vec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

@@ hdl/fpmvt_sum.sv @@
module fpmvt_sum #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fpmvt_pkg::t_prod_mat i_prod,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fpmvt_pkg::t_vec      o_res
);
    import fpmvt_pkg::*;

    logic                r_v2;
    logic                r_v3;
    logic                rdy3;
    t_prod [Dim-1:0][1:0] r_pair;
    t_prod [Dim-1:0][1:0] n_pair;
    t_prod [Dim-1:0]     n_sum;
    t_vec                n_res;
    t_vec                r_res;

    assign rdy3    = !r_v3 || i_ready;
    assign o_ready = !r_v2 || rdy3;
    assign o_valid = r_v3;
    assign o_res   = r_res;

    // sums wrap mod 2^64; kept bits are FRAC_BITS .. FRAC_BITS+31
    always_comb begin
        for (int r = 0; r < Dim; r++) begin
            n_pair[r][0] = i_prod[r][0] + i_prod[r][1];
            n_pair[r][1] = i_prod[r][2] + i_prod[r][3];
            n_sum[r]     = r_pair[r][0] + r_pair[r][1];
            n_res[r]     = n_sum[r][FRAC_BITS +: WordW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= n_pair;
        end
        if (rdy3 && r_v2) begin
            r_res <= n_res;
        end
    end

endmodule
